[rtl/programmable_interrupt_controller_defines.svh]
// assertion macros for the programmable interrupt controller
// no dependencies; included by the top level
`ifndef PROGRAMMABLE_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PROGRAMMABLE_INTERRUPT_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PIC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pic_pkg.sv]
// shared types, constants and the priority pick for the interrupt controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int unsigned LINE_COUNT = 8;
  localparam int unsigned LINE_W     = $clog2(LINE_COUNT);
  localparam int unsigned DATA_W     = 8;

  localparam logic PORT_CMD  = 1'b0;
  localparam logic PORT_DATA = 1'b1;

  // command and init word bit positions
  localparam int unsigned CMD_INIT_BIT  = 4;
  localparam int unsigned ICW1_SKIP_BIT = 1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RAISE = 2'd2,
    REQ_TICK  = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e         req_type;
    logic              port_sel;
    logic [DATA_W-1:0] write_data;
    logic [LINE_W-1:0] irq_line;
    logic              force_nmi;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              int_valid;
    logic [DATA_W-1:0] int_vector;
    logic              nmi_valid;
  } result_t;

  typedef struct packed {
    logic              found;
    logic [LINE_W-1:0] line;
  } pick_t;

  // lowest set line wins
  function automatic pick_t pick_lowest(logic [LINE_COUNT-1:0] pend);
    pick_t p;
    p = '0;
    for (int i = LINE_COUNT - 1; i >= 0; i--) begin
      if (pend[i]) begin
        p.found = 1'b1;
        p.line  = LINE_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/pic_channels.sv]
// valid/ready channel interfaces for items and results
// depends on pic_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pic_item_if;
  logic                                  valid;
  logic                                  ready;
  pic_pkg::req_type_e                    req_type;
  logic                                  port_sel;
  logic [pic_pkg::DATA_W-1:0]            write_data;
  logic [pic_pkg::LINE_W-1:0]            irq_line;
  logic                                  force_nmi;

  modport source (
    output valid, req_type, port_sel, write_data, irq_line, force_nmi,
    input  ready
  );
  modport sink (
    input  valid, req_type, port_sel, write_data, irq_line, force_nmi,
    output ready
  );
endinterface

interface pic_result_if;
  logic                       valid;
  logic                       ready;
  logic [pic_pkg::DATA_W-1:0] read_data;
  logic                       int_valid;
  logic [pic_pkg::DATA_W-1:0] int_vector;
  logic                       nmi_valid;

  modport source (
    output valid, read_data, int_valid, int_vector, nmi_valid,
    input  ready
  );
  modport sink (
    input  valid, read_data, int_valid, int_vector, nmi_valid,
    output ready
  );
endinterface

`default_nettype wire

[rtl/pic_in_stage.sv]
// input register stage: captures one item per transfer
// depends on pic_pkg
`timescale 1ns / 1ps
`default_nettype none

module pic_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire pic_pkg::item_t in_item_i,
  output logic                stage_valid_o,
  output pic_pkg::item_t      stage_item_o,
  input  wire logic           stage_ready_i
);

  logic           valid_q;
  pic_pkg::item_t item_q;

  assign in_ready_o    = !valid_q || stage_ready_i;
  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/pic_exec.sv]
// controller state, per-item update and result register
// depends on pic_pkg
`timescale 1ns / 1ps
`default_nettype none

module pic_exec (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             stage_valid_i,
  input  wire pic_pkg::item_t   stage_item_i,
  output logic                  stage_ready_o,
  output logic                  out_valid_o,
  output pic_pkg::result_t      out_result_o,
  input  wire logic             out_ready_i
);

  typedef enum logic [2:0] {
    STEP_ICW1 = 3'd0,
    STEP_ICW2 = 3'd1,
    STEP_ICW3 = 3'd2,
    STEP_ICW4 = 3'd3,
    STEP_MASK = 3'd4
  } step_e;

  logic [pic_pkg::LINE_COUNT-1:0] req_q, req_d;
  logic [pic_pkg::LINE_COUNT-1:0] mask_q, mask_d;
  logic [pic_pkg::DATA_W-1:0]     icw1_q, icw1_d;
  logic [pic_pkg::DATA_W-1:0]     icw2_q, icw2_d;
  step_e                          step_q, step_d;
  logic                           out_valid_q;
  pic_pkg::result_t               result_q, result_d;
  pic_pkg::pick_t                 pick;
  logic                           fire;

  assign stage_ready_o = !out_valid_q || out_ready_i;
  assign fire          = stage_valid_i && stage_ready_o;
  assign out_valid_o   = out_valid_q;
  assign out_result_o  = result_q;

  always_comb begin
    req_d    = req_q;
    mask_d   = mask_q;
    icw1_d   = icw1_q;
    icw2_d   = icw2_q;
    step_d   = step_q;
    result_d = '0;
    pick     = pic_pkg::pick_lowest(req_q & ~mask_q);
    unique case (stage_item_i.req_type)
      pic_pkg::REQ_READ: begin
        result_d.read_data = (stage_item_i.port_sel == pic_pkg::PORT_CMD) ? req_q : mask_q;
      end
      pic_pkg::REQ_WRITE: begin
        if (stage_item_i.port_sel == pic_pkg::PORT_CMD) begin
          if (stage_item_i.write_data[pic_pkg::CMD_INIT_BIT]) begin
            mask_d = '0;
            icw1_d = stage_item_i.write_data;
            step_d = STEP_ICW2;
          end
        end else begin
          unique case (step_q)
            STEP_ICW1: begin
              icw1_d = stage_item_i.write_data;
              step_d = STEP_ICW2;
            end
            STEP_ICW2: begin
              icw2_d = stage_item_i.write_data;
              step_d = icw1_q[pic_pkg::ICW1_SKIP_BIT] ? STEP_ICW4 : STEP_ICW3;
            end
            STEP_ICW3: step_d = STEP_ICW4;
            STEP_ICW4: step_d = STEP_MASK;
            STEP_MASK: mask_d = stage_item_i.write_data;
            default:   step_d = step_q;
          endcase
        end
      end
      pic_pkg::REQ_RAISE: begin
        req_d = req_q | (pic_pkg::LINE_COUNT'(1) << stage_item_i.irq_line);
      end
      pic_pkg::REQ_TICK: begin
        if (pick.found) begin
          req_d[pick.line]    = 1'b0;
          result_d.int_valid  = 1'b1;
          result_d.int_vector = icw2_q + pic_pkg::DATA_W'(pick.line);
        end
        result_d.nmi_valid = stage_item_i.force_nmi;
      end
      default: result_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= '0;
      mask_q      <= '0;
      icw1_q      <= '0;
      icw2_q      <= '0;
      step_q      <= STEP_ICW1;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (stage_ready_o) begin
        out_valid_q <= stage_valid_i;
      end
      if (fire) begin
        req_q    <= req_d;
        mask_q   <= mask_d;
        icw1_q   <= icw1_d;
        icw2_q   <= icw2_d;
        step_q   <= step_d;
        result_q <= result_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/programmable_interrupt_controller.sv]
// Eight-line interrupt controller, top level.
// Items arrive on item_i (valid/ready): port read, port write, request line
// raise or service tick. Each accepted item yields exactly one result on
// result_o (valid/ready): read data, or the interrupt vector and nmi flag of
// a tick; fields that do not apply to the item are zero.
// Path: an accepted item is held in the input register, then processed
// into the result register, whose contents drive result_o.
// Throughput: one item per cycle; the result register is the only limit, and
// it frees itself in the cycle the receiver takes the result.
// When the receiver stalls, the result holds, the item behind it waits in the
// input register and item_i.ready drops only once both are occupied.
// Reset (rst_ni low, asynchronous): request and mask registers, init words
// and init step clear, both registers empty; items are accepted once reset
// is released.
// Depends on pic_pkg, pic_channels, pic_in_stage, pic_exec and the defines
// header.
`timescale 1ns / 1ps
`default_nettype none
`include "programmable_interrupt_controller_defines.svh"

module programmable_interrupt_controller (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pic_item_if.sink     item_i,
  pic_result_if.source result_o
);

  pic_pkg::item_t   in_item;
  pic_pkg::item_t   stage_item;
  pic_pkg::result_t result;
  logic             in_ready;
  logic             stage_valid;
  logic             stage_ready;
  logic             out_valid;

  assign in_item.req_type   = item_i.req_type;
  assign in_item.port_sel   = item_i.port_sel;
  assign in_item.write_data = item_i.write_data;
  assign in_item.irq_line   = item_i.irq_line;
  assign in_item.force_nmi  = item_i.force_nmi;
  assign item_i.ready       = in_ready;

  pic_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (item_i.valid),
    .in_ready_o    (in_ready),
    .in_item_i     (in_item),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item),
    .stage_ready_i (stage_ready)
  );

  pic_exec u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_item_i  (stage_item),
    .stage_ready_o (stage_ready),
    .out_valid_o   (out_valid),
    .out_result_o  (result),
    .out_ready_i   (result_o.ready)
  );

  assign result_o.valid      = out_valid;
  assign result_o.read_data  = result.read_data;
  assign result_o.int_valid  = result.int_valid;
  assign result_o.int_vector = result.int_vector;
  assign result_o.nmi_valid  = result.nmi_valid;

  // an item leaving the input register always lands in the result register
  `PIC_ASSERT_NEXT(a_stage_to_out, clk_i, rst_ni, stage_valid && stage_ready, out_valid, "item lost between stages")

  // a blocked item in the input register holds
  `PIC_ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, stage_valid && !stage_ready, stage_valid && $stable(stage_item), "blocked item changed")

  // no vector without a maskable interrupt
  `PIC_ASSERT_NOW(a_vector_zero, clk_i, rst_ni, out_valid && !result.int_valid, result.int_vector == '0, "vector without interrupt")

endmodule

`default_nettype wire
